/* design/pdvm_pkg.sv */
package pdvm_pkg;
  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_W = 32;
  localparam int RHW_W = 31;
  localparam int VP_W = 14;
  localparam logic [VP_W-1:0] RESET_WIDTH = 14'd640;
  localparam logic [VP_W-1:0] RESET_HEIGHT = 14'd480;
  localparam logic CFG_WIDTH = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef logic signed [WORD_W-1:0] word_t;

  function automatic word_t sat_word(input logic signed [79:0] v);
    word_t r;
    if (v > 80'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -80'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[WORD_W-1:0];
    end
    return r;
  endfunction
endpackage

/* design/pdvm_recip.sv */
module pdvm_recip #(
  parameter int FRAC_BITS = pdvm_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic advance,
  input  logic [30:0] den,
  output logic [pdvm_pkg::RHW_W-1:0] quot
);
  import pdvm_pkg::*;
  localparam int NW = 2 * FRAC_BITS + 1;
  localparam int QB = 2 * FRAC_BITS + 1;
  localparam int STEPS = 4;
  localparam int NST = (QB + STEPS - 1) / STEPS;
  localparam int QP = NST * STEPS;
  localparam int QW = (QP > RHW_W) ? QP : RHW_W + 1;

  logic [31:0] rem [0:NST];
  logic [QP-1:0] q [0:NST];
  logic [30:0] d [0:NST];
  logic [QW-1:0] q_fin;

  always_comb begin
    rem[0] = '0;
    q[0] = QP'(1) << (2 * FRAC_BITS);
    d[0] = den;
  end

  for (genvar s = 0; s < NST; s++) begin : g_st
    logic [31:0] r_next;
    logic [QP-1:0] q_next;
    always_comb begin
      logic [32:0] t;
      r_next = rem[s];
      q_next = q[s];
      for (int k = 0; k < STEPS; k++) begin
        t = {r_next, q_next[QP-1]};
        q_next = q_next << 1;
        if (t >= {2'b0, d[s]}) begin
          t = t - {2'b0, d[s]};
          q_next[0] = 1'b1;
        end
        r_next = t[31:0];
      end
    end
    always_ff @(posedge clk) begin
      if (advance) begin
        rem[s+1] <= r_next;
        q[s+1] <= q_next;
        d[s+1] <= d[s];
      end
    end
  end

  always_comb begin
    q_fin = QW'(q[NST]);
    if (q_fin[QW-1:RHW_W] != '0) begin
      quot = '1;
    end else begin
      quot = q_fin[RHW_W-1:0];
    end
  end
endmodule

/* design/perspective_divide_viewport_map_core.sv */
// Pipeline: the divider stages, then stage A, stage B and the output register.
// Throughput: one vertex per cycle; the pipeline stalls as a whole only when the output is held.
// Reciprocal: radix-2 restoring divider, four quotient bits per pipeline stage.
// Reset (rst, synchronous): clears all valid bits; viewport registers return to 640 x 480.
module perspective_divide_viewport_map_core #(
  parameter int FRAC_BITS = pdvm_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [31:0] clip_x,
  input  logic signed [31:0] clip_y,
  input  logic signed [31:0] clip_z,
  input  logic signed [31:0] clip_w,
  input  logic signed [31:0] tex_u,
  input  logic signed [31:0] tex_v,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [31:0] screen_x,
  output logic signed [31:0] screen_y,
  output logic signed [31:0] ndc_depth,
  output logic [30:0] recip_w,
  output logic signed [31:0] u_over_w,
  output logic signed [31:0] v_over_w,
  output logic bad_w,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [0:0] cfg_index,
  input  logic [13:0] cfg_data
);
  import pdvm_pkg::*;
  localparam int NST = (2 * FRAC_BITS + 1 + 3) / 4;
  localparam int DEPTH = NST + 3;

  logic [VP_W-1:0] vp_w, vp_h;
  logic [DEPTH-1:0] vld;
  logic advance;
  assign advance = !vld[DEPTH-1] || out_ready;
  assign in_ready = advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp_w <= RESET_WIDTH;
      vp_h <= RESET_HEIGHT;
      vld <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_WIDTH: vp_w <= cfg_data;
          CFG_HEIGHT: vp_h <= cfg_data;
          default: ;
        endcase
      end
      if (advance) vld <= {vld[DEPTH-2:0], in_valid};
    end
  end

  // delay operands alongside the divider
  word_t dx [0:NST], dy [0:NST], dz [0:NST], du [0:NST], dv [0:NST];
  logic dbad [0:NST];
  always_comb begin
    dx[0] = clip_x; dy[0] = clip_y; dz[0] = clip_z;
    du[0] = tex_u; dv[0] = tex_v; dbad[0] = (clip_w <= 0);
  end
  for (genvar s = 0; s < NST; s++) begin : g_dl
    always_ff @(posedge clk) begin
      if (advance) begin
        dx[s+1] <= dx[s]; dy[s+1] <= dy[s]; dz[s+1] <= dz[s];
        du[s+1] <= du[s]; dv[s+1] <= dv[s]; dbad[s+1] <= dbad[s];
      end
    end
  end

  logic [RHW_W-1:0] rhw;
  pdvm_recip #(.FRAC_BITS(FRAC_BITS)) u_recip (
    .clk(clk), .advance(advance),
    .den(clip_w[30:0] == '0 ? 31'd1 : clip_w[30:0]), .quot(rhw)
  );

  // stage A: products
  logic signed [63:0] px, py, pz, pu, pv;
  logic [RHW_W-1:0] rhw_a;
  logic bad_a;
  always_ff @(posedge clk) begin
    if (advance) begin
      px <= dx[NST] * $signed({1'b0, rhw});
      py <= dy[NST] * $signed({1'b0, rhw});
      pz <= dz[NST] * $signed({1'b0, rhw});
      pu <= du[NST] * $signed({1'b0, rhw});
      pv <= dv[NST] * $signed({1'b0, rhw});
      rhw_a <= rhw;
      bad_a <= dbad[NST];
    end
  end

  // stage B: shift, saturate, screen multiply
  word_t nx, ny, nz_b, nu_b, nv_b;
  always_comb begin
    nx = sat_word(80'(px >>> FRAC_BITS));
    ny = sat_word(80'(py >>> FRAC_BITS));
  end
  logic signed [48:0] sx, sy;
  word_t nz, nu, nv;
  logic [RHW_W-1:0] rhw_b;
  logic bad_b;
  always_ff @(posedge clk) begin
    if (advance) begin
      sx <= (49'(nx) + (49'sd1 <<< FRAC_BITS)) * $signed({1'b0, vp_w});
      sy <= (49'(ny) + (49'sd1 <<< FRAC_BITS)) * $signed({1'b0, vp_h});
      nz <= sat_word(80'(pz >>> FRAC_BITS));
      nu <= sat_word(80'(pu >>> FRAC_BITS));
      nv <= sat_word(80'(pv >>> FRAC_BITS));
      rhw_b <= rhw_a;
      bad_b <= bad_a;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      screen_x <= bad_b ? '0 : sat_word(80'(sx >>> 1));
      screen_y <= bad_b ? '0 : sat_word(80'(sy >>> 1));
      ndc_depth <= bad_b ? '0 : nz;
      recip_w <= bad_b ? '0 : rhw_b;
      u_over_w <= bad_b ? '0 : nu;
      v_over_w <= bad_b ? '0 : nv;
      bad_w <= bad_b;
    end
  end
  assign out_valid = vld[DEPTH-1];
endmodule

/* verif/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pdvm_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int LIMIT = 400000;

  typedef struct packed {
    word_t x, y, z, w, u, v;
  } vertex_t;

  typedef struct packed {
    word_t sx, sy, depth;
    logic [RHW_W-1:0] rhw;
    word_t uw, vw;
    logic bad;
  } mapped_t;

  typedef struct {
    vertex_t vtx;
    bit known;
    mapped_t res;
  } row_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_ready;
  word_t clip_x = 0, clip_y = 0, clip_z = 0, clip_w = 0, tex_u = 0, tex_v = 0;
  logic out_valid, out_ready = 0;
  word_t screen_x, screen_y, ndc_depth, u_over_w, v_over_w;
  logic [RHW_W-1:0] recip_w;
  logic bad_w;
  logic cfg_valid = 0, cfg_ready;
  logic [0:0] cfg_index = CFG_WIDTH;
  logic [VP_W-1:0] cfg_data = 0;

  perspective_divide_viewport_map_core dut (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  logic [VP_W-1:0] vp_w, vp_h;
  mapped_t pending_q[$];
  int errors = 0, n_sent = 0, n_got = 0, n_bad = 0, n_sat = 0;
  int cycles = 0;
  bit hold_off = 0;

  function automatic longint floor_div2n(longint a, int s);
    return a >>> s;
  endfunction

  function automatic longint clamp32(longint a);
    if (a > 64'sd2147483647) return 64'sd2147483647;
    if (a < -64'sd2147483648) return -64'sd2147483648;
    return a;
  endfunction

  function automatic mapped_t map_vertex(vertex_t t);
    mapped_t r;
    longint w, q, nx, ny;
    r = '0;
    w = longint'(t.w);
    if (w <= 0) begin
      r.bad = 1;
      return r;
    end
    q = (64'sd1 <<< (2 * FB)) / w;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    nx = clamp32(floor_div2n(longint'(t.x) * q, FB));
    ny = clamp32(floor_div2n(longint'(t.y) * q, FB));
    r.sx = word_t'(clamp32(floor_div2n((nx + (64'sd1 <<< FB)) * longint'(vp_w), 1)));
    r.sy = word_t'(clamp32(floor_div2n((ny + (64'sd1 <<< FB)) * longint'(vp_h), 1)));
    r.depth = word_t'(clamp32(floor_div2n(longint'(t.z) * q, FB)));
    r.rhw = q[RHW_W-1:0];
    r.uw = word_t'(clamp32(floor_div2n(longint'(t.u) * q, FB)));
    r.vw = word_t'(clamp32(floor_div2n(longint'(t.v) * q, FB)));
    return r;
  endfunction

  function automatic word_t rand_coord();
    case ($urandom_range(0, 5))
      0: return word_t'($urandom);
      1: return word_t'($urandom_range(0, 32'h7ffff)) - 32'sh40000;
      2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return word_t'($urandom_range(0, 32'h3ffff)) - 32'sh20000;
    endcase
  endfunction

  function automatic vertex_t rand_vertex();
    vertex_t t;
    t.x = rand_coord();
    t.y = rand_coord();
    t.z = rand_coord();
    t.u = rand_coord();
    t.v = rand_coord();
    case ($urandom_range(0, 9))
      0: t.w = word_t'($urandom);
      1: t.w = -word_t'($urandom_range(0, 100));
      2: t.w = word_t'($urandom_range(1, 4));
      3: t.w = 32'sh40000000 | word_t'($urandom_range(0, 32'h3fffffff));
      default: t.w = word_t'($urandom_range(1, 32'h7ffff));
    endcase
    return t;
  endfunction

  task automatic send_vertex(vertex_t t, bit known, mapped_t res);
    mapped_t m;
    int n;
    n = $urandom_range(0, 7);
    if (n != 0) begin
      in_valid <= 0;
      repeat (n) @(posedge clk);
    end
    clip_x <= t.x; clip_y <= t.y; clip_z <= t.z;
    clip_w <= t.w; tex_u <= t.u; tex_v <= t.v;
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    m = map_vertex(t);
    if (known && m !== res)
      $display("%0t model disagrees with table row: %h vs %h", $time, m, res);
    pending_q = {pending_q, (known ? res : m)};
    n_sent++;
    if (m.bad) n_bad++;
  endtask

  task automatic write_reg(logic [0:0] idx, logic [VP_W-1:0] val);
    in_valid <= 0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    if (idx == CFG_WIDTH) vp_w = val; else vp_h = val;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  int stall_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 0;
    end else if (out_valid && out_ready) begin
      mapped_t e, a;
      a = {screen_x, screen_y, ndc_depth, recip_w, u_over_w, v_over_w, bad_w};
      n_got <= n_got + 1;
      if (pending_q.size() == 0) begin
        $display("%0t unexpected transaction: actual %h", $time, a);
        errors <= errors + 1;
      end else begin
        e = pending_q.pop_front();
        if (a !== e) begin
          $display("%0t mismatch: expected %h actual %h", $time, e, a);
          errors <= errors + 1;
        end
        if (e.sx == 32'sh7fffffff || e.sx == 32'sh80000000) n_sat <= n_sat + 1;
      end
      stall_left = $urandom_range(0, 7);
      if ($urandom_range(0, 3) == 0) stall_left = 0;
      out_ready <= (stall_left == 0) && !hold_off;
    end else if (hold_off) begin
      out_ready <= 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= (stall_left == 0);
    end else begin
      out_ready <= 1;
    end
  end

  initial begin
    row_t rows[$];
    row_t r;
    mapped_t z;
    int k;
    vp_w = RESET_WIDTH;
    vp_h = RESET_HEIGHT;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    z = '0;
    // bad w rows: fixed result
    z.bad = 1;
    r.known = 1; r.res = z;
    r.vtx = '{32'sh7fffffff, 32'sh80000000, 1, 0, 5, 6}; rows = {rows, r};
    r.vtx = '{1, 2, 3, -1, 4, 5}; rows = {rows, r};
    r.vtx = '{0, 0, 0, 32'sh80000000, 0, 0}; rows = {rows, r};
    // w = 1.0, all zero: center of the 640x480 screen
    z = '0;
    z.sx = 32'sd320 <<< 16; z.sy = 32'sd240 <<< 16; z.rhw = 31'h10000;
    r.vtx = '{0, 0, 0, 32'sh10000, 0, 0}; r.res = z; rows = {rows, r};
    r.known = 0;
    r.vtx = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1, 32'sh80000000, 32'sh7fffffff};
    rows = {rows, r};
    r.vtx = '{32'sh10000, -32'sh10000, 32'sh8000, 32'sh10000, 32'sh10000, 0}; rows = {rows, r};
    r.vtx = '{-1, -1, -1, 32'sh7fffffff, -1, 1}; rows = {rows, r};
    r.vtx = '{5, 6, 7, 2, 8, 9}; rows = {rows, r};
    r.vtx = '{32'sh20000, 32'sh30000, -32'sh40000, 32'sh18000, 32'sh1234, -32'sh5678};
    rows = {rows, r};
    foreach (rows[i]) send_vertex(rows[i].vtx, rows[i].known, rows[i].res);

    write_reg(CFG_WIDTH, 14'd8192);
    write_reg(CFG_HEIGHT, 14'd1);
    for (k = 0; k < 300; k++) send_vertex(rand_vertex(), 0, z);

    // long output hold-off: pipeline fills and backs up the input
    fork
      begin
        hold_off = 1;
        repeat (200) @(posedge clk);
        hold_off = 0;
      end
      for (k = 0; k < 60; k++) send_vertex(rand_vertex(), 0, z);
    join

    write_reg(CFG_WIDTH, 14'd0);
    write_reg(CFG_HEIGHT, 14'h3fff);
    for (k = 0; k < 300; k++) send_vertex(rand_vertex(), 0, z);
    write_reg(CFG_WIDTH, 14'd1);
    write_reg(CFG_HEIGHT, 14'd8192);
    for (k = 0; k < 300; k++) send_vertex(rand_vertex(), 0, z);
    for (int p = 0; p < 3; p++) begin
      write_reg(CFG_WIDTH, VP_W'($urandom_range(1, 8192)));
      write_reg(CFG_HEIGHT, VP_W'($urandom_range(1, 8192)));
      for (k = 0; k < 180; k++) send_vertex(rand_vertex(), 0, z);
    end
    in_valid <= 0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    $display("Sent %0d vertices (%0d with bad w), %0d results checked, %0d x-saturated;",
             n_sent, n_bad, n_got, n_sat);
    $display("viewport sizes swept over zero, one, 8192 and 16383 plus random.");
    if (errors == 0 && pending_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

/* perspective_divide_viewport_map_core.f */
design/pdvm_pkg.sv
design/pdvm_recip.sv
design/perspective_divide_viewport_map_core.sv
verif/tb.sv
